/* hw/rtl/htss_pkg.sv */
package htss_pkg;

  localparam int NUM_TIMERS = 4;
  localparam int MAX_TIMERS = 4;
  localparam int TIDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam int COUNT_W    = 34;
  localparam int LINE_CD_W  = 12;
  localparam int ELAPSED_W  = 10;
  localparam int TCTRL_W    = 26;
  localparam int DCTRL_W    = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 104;

  localparam logic [TCTRL_W-1:0] TCTRL0_RESET = 26'h3010000;
  localparam logic [TCTRL_W-1:0] TCTRL_RESET  = 26'h0010000;

  localparam logic [LINE_CD_W-1:0] VISIBLE_CYCLES = 12'd960;
  localparam logic [LINE_CD_W-1:0] HBLANK_CYCLES  = 12'd272;
  localparam logic [7:0]           VBLANK_LINE    = 8'd160;
  localparam logic [7:0]           FRAME_LINES    = 8'd228;

  typedef enum logic [1:0] {
    TM_OFF      = 2'd0,
    TM_PRESCALE = 2'd1,
    TM_CASCADE  = 2'd2,
    TM_UNUSED   = 2'd3
  } tmode_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TIMER0  = 3'd0,
    REG_TIMER1  = 3'd1,
    REG_TIMER2  = 3'd2,
    REG_TIMER3  = 3'd3,
    REG_DISPLAY = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_CHK,
    ST_RLD,
    ST_LINE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                 step;
    logic [ELAPSED_W-1:0] elapsed;
  } line_ctl_t;

  typedef struct packed {
    logic [LINE_CD_W-1:0] countdown;
    logic [7:0]           scanline;
    logic                 vblank;
    logic                 hblank;
    logic                 match;
    logic                 hdma;
    logic                 vdma;
    logic                 fend;
    logic [2:0]           irq;
  } line_stat_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] timer_value_3;
    logic [15:0] timer_value_2;
    logic [15:0] timer_value_1;
    logic [15:0] timer_value_0;
    logic [3:0]  sound_ticks;
    logic        frame_end;
    logic        vblank_dma_start;
    logic        hblank_dma_start;
    logic [2:0]  status_flags;
    logic [7:0]  line_number;
    logic [9:0]  next_cycles;
    logic [6:0]  irq_mask;
  } out_item_t;

endpackage

/* hw/rtl/handheld_timer_and_scanline_step_unit.sv */
// Channel     Dir  Handshake                     Payload
// s_axis      in   s_axis_tvalid/s_axis_tready   tdata: elapsed_cycles
// m_axis      out  m_axis_tvalid/m_axis_tready   tdata: result fields, see port
// cfg         in   cfg_valid_i/cfg_ready_o       cfg_addr_i, cfg_data_i
//
// After its transfer a step visits SUB for each timer, CHK as well when it is
// active and RLD as well when it overflows, all through a single 34-bit adder,
// then LINE for the scanline and FIN for each timer for the visible values and
// the cycle budget. A new step is accepted once the sequencer is back in idle;
// a waiting result holds only the last FIN state. Reset restores the control
// registers, counts and scanline state at once, but not elapsed, budget, vis or out.
module handheld_timer_and_scanline_step_unit
  import htss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [9:0] elapsed_cycles
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [6:0] irq_mask, [16:7] next_cycles, [24:17] line_number, [27:25] status_flags,
  // [28] hblank_dma_start, [29] vblank_dma_start, [30] frame_end,
  // [34:31] sound_ticks, [50:35] timer_value_0, [66:51] timer_value_1,
  // [82:67] timer_value_2, [98:83] timer_value_3
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [TCTRL_W-1:0]    cfg_data_i
);

  state_e state_q, state_d;

  logic [TCTRL_W-1:0]   ctrl_q [NUM_TIMERS];
  logic [COUNT_W-1:0]   count_q [NUM_TIMERS];
  logic [DCTRL_W-1:0]   dctrl_q;
  logic [15:0]          vis_q [MAX_TIMERS];
  logic [NUM_TIMERS-1:0] have_q;
  logic [3:0]           tirq_q;
  logic [3:0]           snd_q;
  logic                 casc_q;
  logic [TIDX_W-1:0]    idx_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [COUNT_W-1:0]   budget_q;
  logic                 m_valid_q;
  out_item_t            out_q;

  logic                 in_xfer;
  logic                 last_idx;
  logic [TIDX_W-1:0]    nxt_idx;
  tmode_e               mode_cur;
  tmode_e               mode_nxt;
  logic [COUNT_W-1:0]   count_cur;
  logic                 ovf_cur;
  logic                 casc_ok;
  logic                 out_free;
  logic [COUNT_W-1:0]   reload_cur;

  logic                 add_we;
  logic [TIDX_W-1:0]    add_idx;
  logic [COUNT_W-1:0]   add_b;
  logic [COUNT_W-1:0]   add_res;

  logic                 vis_we;
  logic [TIDX_W-1:0]    vis_idx;
  logic                 vis_shift_en;
  logic [15:0]          vis_res;
  logic [15:0]          vis_out [MAX_TIMERS];

  logic                 adv;
  logic                 fin_done;
  logic [COUNT_W-1:0]   budget_cur;
  logic [COUNT_W-1:0]   budget_cand;
  logic [9:0]           budget_clamp;

  line_ctl_t            line_ctl;
  line_stat_t           line_stat;
  out_item_t            out_d;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign last_idx  = (idx_q == TIDX_W'(NUM_TIMERS - 1));
  assign nxt_idx   = last_idx ? '0 : TIDX_W'(idx_q + 1'b1);
  assign mode_cur  = tmode_e'(ctrl_q[idx_q][18:17]);
  assign mode_nxt  = tmode_e'(ctrl_q[nxt_idx][18:17]);
  assign count_cur = count_q[idx_q];
  assign ovf_cur   = count_cur[COUNT_W-1] || (count_cur == '0);
  assign casc_ok   = !last_idx && (mode_nxt == TM_CASCADE);
  assign out_free  = !m_valid_q || m_axis_tready;
  assign reload_cur = COUNT_W'(ctrl_q[idx_q][16:0]) << ctrl_q[idx_q][22:19];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_SUB;
      end
      ST_SUB: begin
        if (mode_cur == TM_PRESCALE || mode_cur == TM_CASCADE) begin
          state_d = ST_CHK;
        end else if (last_idx) begin
          state_d = ST_LINE;
        end
      end
      ST_CHK: begin
        if (ovf_cur) begin
          state_d = ST_RLD;
        end else begin
          state_d = last_idx ? ST_LINE : ST_SUB;
        end
      end
      ST_RLD: begin
        state_d = last_idx ? ST_LINE : ST_SUB;
      end
      ST_LINE: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (last_idx && out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    add_we        = 1'b0;
    add_idx       = idx_q;
    add_b         = '0;
    vis_we        = 1'b0;
    vis_idx       = idx_q;
    vis_shift_en  = 1'b1;
    adv           = 1'b0;
    fin_done      = 1'b0;
    line_ctl      = '{step: 1'b0, elapsed: elapsed_q};
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_SUB: begin
        add_b  = COUNT_W'(0) - COUNT_W'(elapsed_q);
        add_we = (mode_cur == TM_PRESCALE);
        adv    = !(mode_cur == TM_PRESCALE || mode_cur == TM_CASCADE);
      end
      ST_CHK: begin
        add_idx = nxt_idx;
        add_b   = '1;
        add_we  = ovf_cur && casc_ok;
        vis_we  = (mode_cur == TM_PRESCALE);
        adv     = !ovf_cur;
      end
      ST_RLD: begin
        add_b        = reload_cur;
        add_we       = 1'b1;
        vis_idx      = nxt_idx;
        vis_shift_en = 1'b0;
        vis_we       = casc_q;
        adv          = 1'b1;
      end
      ST_LINE: begin
        line_ctl.step = 1'b1;
      end
      ST_FIN: begin
        vis_shift_en = (mode_cur != TM_CASCADE);
        vis_we       = !have_q[idx_q];
        adv          = !last_idx;
        fin_done     = last_idx && out_free;
      end
      default: begin
      end
    endcase
  end

  assign add_res = count_q[add_idx] + add_b;

  htss_vis u_vis (
    .count_i    (count_q[vis_idx]),
    .shift_en_i (vis_shift_en),
    .shift_i    (ctrl_q[vis_idx][22:19]),
    .value_o    (vis_res)
  );

  htss_line u_line (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (line_ctl),
    .display_ctrl_i (dctrl_q),
    .stat_o         (line_stat)
  );

  assign budget_cur  = (idx_q == '0) ? COUNT_W'($signed(line_stat.countdown)) : budget_q;
  assign budget_cand = ((mode_cur == TM_PRESCALE) && ($signed(count_cur) < $signed(budget_cur)))
                       ? count_cur : budget_cur;

  always_comb begin
    if (budget_cand[COUNT_W-1]) begin
      budget_clamp = '0;
    end else if (|budget_cand[COUNT_W-2:10]) begin
      budget_clamp = '1;
    end else begin
      budget_clamp = budget_cand[9:0];
    end
  end

  always_comb begin
    for (int n = 0; n < MAX_TIMERS; n++) begin
      if (n < NUM_TIMERS) begin
        vis_out[n] = (vis_we && (vis_idx == TIDX_W'(n))) ? vis_res : vis_q[n];
      end else begin
        vis_out[n] = '0;
      end
    end
  end

  always_comb begin
    out_d                  = '0;
    out_d.irq_mask         = {tirq_q, line_stat.irq};
    out_d.next_cycles      = budget_clamp;
    out_d.line_number      = line_stat.scanline;
    out_d.status_flags     = {line_stat.match, line_stat.hblank, line_stat.vblank};
    out_d.hblank_dma_start = line_stat.hdma;
    out_d.vblank_dma_start = line_stat.vdma;
    out_d.frame_end        = line_stat.fend;
    out_d.sound_ticks      = snd_q;
    out_d.timer_value_0    = vis_out[0];
    out_d.timer_value_1    = vis_out[1];
    out_d.timer_value_2    = vis_out[2];
    out_d.timer_value_3    = vis_out[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      have_q    <= '0;
      tirq_q    <= '0;
      snd_q     <= '0;
      casc_q    <= 1'b0;
      m_valid_q <= 1'b0;
      dctrl_q   <= '0;
      for (int n = 0; n < NUM_TIMERS; n++) begin
        ctrl_q[n]  <= (n == 0) ? TCTRL0_RESET : TCTRL_RESET;
        count_q[n] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        if (cfg_addr_i == REG_DISPLAY) begin
          dctrl_q <= cfg_data_i[DCTRL_W-1:0];
        end else if (cfg_addr_i < CFG_ADDR_W'(NUM_TIMERS)) begin
          ctrl_q[cfg_addr_i[TIDX_W-1:0]]  <= cfg_data_i;
          count_q[cfg_addr_i[TIDX_W-1:0]] <= COUNT_W'(cfg_data_i[16:0]) << cfg_data_i[22:19];
        end
      end else if (add_we) begin
        count_q[add_idx] <= add_res;
      end

      if (in_xfer) begin
        idx_q  <= '0;
        have_q <= '0;
        tirq_q <= '0;
        snd_q  <= '0;
      end else if (adv || state_q == ST_LINE || fin_done) begin
        idx_q <= (state_q == ST_LINE) ? '0 : nxt_idx;
      end

      if (vis_we && state_q != ST_FIN) begin
        have_q[vis_idx] <= 1'b1;
      end

      if (state_q == ST_CHK) begin
        casc_q <= ovf_cur && casc_ok;
        if (ovf_cur) begin
          tirq_q[idx_q] <= ctrl_q[idx_q][23];
          if (idx_q == TIDX_W'(0)) begin
            snd_q[1:0] <= ctrl_q[idx_q][25:24];
          end else if (idx_q == TIDX_W'(1)) begin
            snd_q[3:2] <= ctrl_q[idx_q][25:24];
          end
        end
      end

      if (fin_done) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      elapsed_q <= s_axis_tdata[ELAPSED_W-1:0];
    end
    if (vis_we) begin
      vis_q[vis_idx] <= vis_res;
    end
    if (state_q == ST_FIN && !last_idx) begin
      budget_q <= budget_cand;
    end
    if (fin_done) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

endmodule

/* hw/rtl/htss_vis.sv */
module htss_vis
  import htss_pkg::*;
(
  input  logic [COUNT_W-1:0] count_i,
  input  logic               shift_en_i,
  input  logic [3:0]         shift_i,
  output logic [15:0]        value_o
);

  logic [COUNT_W-1:0] shifted;
  logic [15:0]        low;

  assign shifted = $unsigned($signed(count_i) >>> shift_i);
  assign low     = shift_en_i ? shifted[15:0] : count_i[15:0];
  assign value_o = 16'(16'd0 - low);

endmodule

/* hw/rtl/htss_line.sv */
module htss_line
  import htss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  line_ctl_t          ctl_i,
  input  logic [DCTRL_W-1:0] display_ctrl_i,
  output line_stat_t         stat_o
);

  line_stat_t           stat_q, stat_d;
  logic [LINE_CD_W-1:0] cd_sub;
  logic [7:0]           line_inc;

  assign cd_sub   = stat_q.countdown - LINE_CD_W'(ctl_i.elapsed);
  assign line_inc = stat_q.scanline + 8'd1;

  always_comb begin
    stat_d = stat_q;
    if (ctl_i.step) begin
      stat_d.hdma = 1'b0;
      stat_d.vdma = 1'b0;
      stat_d.fend = 1'b0;
      stat_d.irq  = '0;
      stat_d.countdown = cd_sub;
      if (cd_sub[LINE_CD_W-1] || (cd_sub == '0)) begin
        if (!stat_q.hblank) begin
          stat_d.countdown = cd_sub + HBLANK_CYCLES;
          stat_d.hblank    = 1'b1;
          stat_d.hdma      = !stat_q.vblank;
          stat_d.irq[1]    = display_ctrl_i[1];
        end else begin
          stat_d.countdown = cd_sub + VISIBLE_CYCLES;
          stat_d.hblank    = 1'b0;
          stat_d.scanline  = line_inc;
          if (line_inc == VBLANK_LINE) begin
            stat_d.vblank = 1'b1;
            stat_d.vdma   = 1'b1;
            stat_d.irq[0] = display_ctrl_i[0];
          end else if (line_inc == FRAME_LINES) begin
            stat_d.vblank   = 1'b0;
            stat_d.fend     = 1'b1;
            stat_d.scanline = '0;
          end
          stat_d.match  = (stat_d.scanline == display_ctrl_i[10:3]);
          stat_d.irq[2] = stat_d.match & display_ctrl_i[2];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '{countdown: VISIBLE_CYCLES, default: '0};
    end else begin
      stat_q <= stat_d;
    end
  end

  assign stat_o = stat_q;

endmodule
